@@ src/swizzled_bank_conflict_counter_core_assert.svh @@
// Assertion macros for the bank conflict counter checker.
// Needs nothing; included by the checker file only.
`ifndef SWIZZLED_BANK_CONFLICT_COUNTER_CORE_ASSERT_SVH
`define SWIZZLED_BANK_CONFLICT_COUNTER_CORE_ASSERT_SVH

// property holds on every edge out of reset
`define SBCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define SBCC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/sbcc_pkg.sv @@
// Shared constants and types for the bank conflict counter.
// No dependencies.
package sbcc_pkg;

    localparam int NUM_BANKS       = 32;
    localparam int LANES_PER_GROUP = 32;
    localparam int SCANNED_LINES   = 8;
    localparam int MAX_TILE_DIM    = 4096;

    localparam int BANK_W  = (NUM_BANKS > 2) ? $clog2(NUM_BANKS) : 1;
    localparam int LANE_W  = (LANES_PER_GROUP > 2) ? $clog2(LANES_PER_GROUP) : 1;
    localparam int LINE_W  = (SCANNED_LINES > 2) ? $clog2(SCANNED_LINES) : 1;
    localparam int IDX_W   = (LANE_W > LINE_W) ? LANE_W : LINE_W;
    localparam int SWZ_W   = 3;
    localparam int DIM_W   = 13;
    localparam int TOTAL_W = 9;

    // swizzle settings held for one item
    typedef struct packed {
        logic [SWZ_W-1:0] bit_count;
        logic [SWZ_W-1:0] row_shift;
        logic [SWZ_W-1:0] column_shift;
    } t_swz;

    // control from sequencer to the bank-seen flags
    typedef struct packed {
        logic step;   // one lane is checked this cycle
        logic clear;  // last lane of a group: wipe all flags
    } t_seen_ctl;

endpackage

@@ src/sbcc_bank_unit.sv @@
// Shared swizzle and bank address unit: one lane per cycle.
// Depends on sbcc_pkg.
module sbcc_bank_unit (
    input  sbcc_pkg::t_swz                 i_swz,
    input  logic [sbcc_pkg::BANK_W-1:0]    i_pitch,
    input  logic [sbcc_pkg::IDX_W-1:0]     i_row,
    input  logic [sbcc_pkg::IDX_W-1:0]     i_col,
    output logic [sbcc_pkg::BANK_W-1:0]    o_bank
);
    localparam int MOVE_W = sbcc_pkg::IDX_W + 7;
    localparam int WIDE_W = MOVE_W + sbcc_pkg::BANK_W;

    logic [sbcc_pkg::IDX_W-1:0]  mask;
    logic [sbcc_pkg::IDX_W-1:0]  sel;
    logic [MOVE_W-1:0]           moved;
    logic [WIDE_W-1:0]           swz_col;
    logic [sbcc_pkg::BANK_W-1:0] prod;

    // mask of bit_count ones; shifting past the width leaves all ones
    assign mask    = ~({sbcc_pkg::IDX_W{1'b1}} << i_swz.bit_count);
    assign sel     = (i_row >> i_swz.row_shift) & mask;
    assign moved   = MOVE_W'(sel) << i_swz.column_shift;
    assign swz_col = WIDE_W'(i_col) ^ WIDE_W'(moved);
    // only the low bank bits of row * pitch survive the modulo
    assign prod    = sbcc_pkg::BANK_W'(WIDE_W'(i_row) * WIDE_W'(i_pitch));
    assign o_bank  = prod + swz_col[sbcc_pkg::BANK_W-1:0];

endmodule

@@ src/sbcc_seen_flags.sv @@
// Bank-seen flags for the current group; reports a repeat hit.
// Depends on sbcc_pkg.
module sbcc_seen_flags (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sbcc_pkg::t_seen_ctl          i_ctl,
    input  logic [sbcc_pkg::BANK_W-1:0]  i_bank,
    output logic                         o_hit
);
    logic [sbcc_pkg::NUM_BANKS-1:0] r_seen;
    logic [sbcc_pkg::NUM_BANKS-1:0] n_seen;

    assign o_hit = r_seen[i_bank];

    always_comb begin
        n_seen = r_seen;
        if (i_ctl.step) begin
            if (i_ctl.clear) begin
                n_seen = '0;
            end else begin
                n_seen[i_bank] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

@@ src/swizzled_bank_conflict_counter_core.sv @@
// Top level of the swizzled bank conflict counter: sequencer and total.
// Depends on sbcc_pkg, sbcc_bank_unit, sbcc_seen_flags.
//
// Pulse start while busy is low to hand in one item. The block walks two
// sets of groups: the first min(rows, 8) rows with lanes walking columns,
// then the first min(columns, 8) columns with lanes walking rows; a group
// has min(walked dimension, 32) lanes. One lane goes through the shared
// swizzle/bank unit per cycle, and the bank-seen flags are cleared in
// the cycle of a group's last lane, costing nothing extra. The result
// shows on o_conflict_total for the single cycle o_done is high, in the
// cycle after the last lane; the receiver cannot stall it, so it must
// take it then. An empty tile (zero rows or columns) gives 0 in the
// cycle after start without raising busy. busy is low in the o_done
// cycle, so the next item may start there.
module swizzled_bank_conflict_counter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sbcc_pkg::SWZ_W-1:0]     i_swizzle_bit_count,
    input  logic [sbcc_pkg::SWZ_W-1:0]     i_row_shift,
    input  logic [sbcc_pkg::SWZ_W-1:0]     i_column_shift,
    input  logic [sbcc_pkg::DIM_W-1:0]     i_tile_row_count,
    input  logic [sbcc_pkg::DIM_W-1:0]     i_tile_column_count,
    output logic                           o_done,
    output logic [sbcc_pkg::TOTAL_W-1:0]   o_conflict_total
);
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    localparam logic [sbcc_pkg::DIM_W-1:0] MAX_DIM =
        sbcc_pkg::DIM_W'(sbcc_pkg::MAX_TILE_DIM);
    localparam logic [sbcc_pkg::DIM_W-1:0] LINES_DIM =
        sbcc_pkg::DIM_W'(sbcc_pkg::SCANNED_LINES);
    localparam logic [sbcc_pkg::DIM_W-1:0] LANES_DIM =
        sbcc_pkg::DIM_W'(sbcc_pkg::LANES_PER_GROUP);

    // phase 0: lanes walk columns; phase 1: lanes walk rows
    t_state                          r_state, n_state;
    logic                            r_phase, n_phase;
    logic [sbcc_pkg::LINE_W-1:0]     r_line, n_line;
    logic [sbcc_pkg::LANE_W-1:0]     r_lane, n_lane;
    logic [sbcc_pkg::LINE_W-1:0]     r_last_line [2];
    logic [sbcc_pkg::LANE_W-1:0]     r_last_lane [2];
    sbcc_pkg::t_swz                  r_swz;
    logic [sbcc_pkg::BANK_W-1:0]     r_pitch;
    logic [sbcc_pkg::TOTAL_W-1:0]    r_total, n_total;
    logic                            r_done, n_done;

    logic                            accept;
    logic                            empty;
    logic [sbcc_pkg::DIM_W-1:0]      cols_sat;
    logic [sbcc_pkg::DIM_W-1:0]      row_m1, col_m1;
    logic [sbcc_pkg::IDX_W-1:0]      row_idx, col_idx;
    logic [sbcc_pkg::BANK_W-1:0]     bank;
    logic                            hit;
    logic                            group_end;
    logic                            phase_end;
    sbcc_pkg::t_seen_ctl             seen_ctl;

    assign accept   = start && !busy;
    assign empty    = (i_tile_row_count == '0) || (i_tile_column_count == '0);
    assign cols_sat = (i_tile_column_count > MAX_DIM) ? MAX_DIM : i_tile_column_count;
    assign row_m1   = i_tile_row_count - 1'b1;
    assign col_m1   = i_tile_column_count - 1'b1;

    // current lane position in the tile
    always_comb begin
        if (r_phase) begin
            row_idx = sbcc_pkg::IDX_W'(r_lane);
            col_idx = sbcc_pkg::IDX_W'(r_line);
        end else begin
            row_idx = sbcc_pkg::IDX_W'(r_line);
            col_idx = sbcc_pkg::IDX_W'(r_lane);
        end
    end

    sbcc_bank_unit u_bank (
        .i_swz   (r_swz),
        .i_pitch (r_pitch),
        .i_row   (row_idx),
        .i_col   (col_idx),
        .o_bank  (bank)
    );

    assign group_end      = (r_lane == r_last_lane[r_phase]);
    assign phase_end      = group_end && (r_line == r_last_line[r_phase]);
    assign seen_ctl.step  = (r_state == ST_SCAN);
    assign seen_ctl.clear = group_end;

    sbcc_seen_flags u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seen_ctl),
        .i_bank  (bank),
        .o_hit   (hit)
    );

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_line  = r_line;
        n_lane  = r_lane;
        n_total = r_total;
        n_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_phase = 1'b0;
                    n_line  = '0;
                    n_lane  = '0;
                    n_total = '0;
                    if (empty) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // a lane on an already-seen bank is one conflict; saturate
                if (hit && (r_total != '1)) begin
                    n_total = r_total + 1'b1;
                end
                if (!group_end) begin
                    n_lane = r_lane + 1'b1;
                end else begin
                    n_lane = '0;
                    if (!phase_end) begin
                        n_line = r_line + 1'b1;
                    end else begin
                        n_line = '0;
                        if (r_phase) begin
                            n_state = ST_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_phase = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
            r_line  <= '0;
            r_lane  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_line  <= n_line;
            r_lane  <= n_lane;
            r_done  <= n_done;
        end
    end

    // item payload; no reset needed
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        if (accept) begin
            r_swz.bit_count    <= i_swizzle_bit_count;
            r_swz.row_shift    <= i_row_shift;
            r_swz.column_shift <= i_column_shift;
            r_pitch            <= cols_sat[sbcc_pkg::BANK_W-1:0];
            // phase 0: lines from rows, lanes from columns
            r_last_line[0] <= (i_tile_row_count >= LINES_DIM) ?
                              sbcc_pkg::LINE_W'(sbcc_pkg::SCANNED_LINES - 1) :
                              row_m1[sbcc_pkg::LINE_W-1:0];
            r_last_lane[0] <= (i_tile_column_count >= LANES_DIM) ?
                              sbcc_pkg::LANE_W'(sbcc_pkg::LANES_PER_GROUP - 1) :
                              col_m1[sbcc_pkg::LANE_W-1:0];
            // phase 1: lines from columns, lanes from rows
            r_last_line[1] <= (i_tile_column_count >= LINES_DIM) ?
                              sbcc_pkg::LINE_W'(sbcc_pkg::SCANNED_LINES - 1) :
                              col_m1[sbcc_pkg::LINE_W-1:0];
            r_last_lane[1] <= (i_tile_row_count >= LANES_DIM) ?
                              sbcc_pkg::LANE_W'(sbcc_pkg::LANES_PER_GROUP - 1) :
                              row_m1[sbcc_pkg::LANE_W-1:0];
        end
    end

    assign busy             = (r_state == ST_SCAN);
    assign o_done           = r_done;
    assign o_conflict_total = r_total;

endmodule

@@ src/sbcc_checker.sv @@
// Port-level checker for the bank conflict counter, bound to the top level.
// Depends on sbcc_pkg and swizzled_bank_conflict_counter_core_assert.svh.
`include "swizzled_bank_conflict_counter_core_assert.svh"

module sbcc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [sbcc_pkg::DIM_W-1:0]     i_tile_row_count,
    input  logic [sbcc_pkg::DIM_W-1:0]     i_tile_column_count,
    input  logic                           o_done,
    input  logic [sbcc_pkg::TOTAL_W-1:0]   o_conflict_total
);
    logic acc_full;
    logic acc_empty;

    assign acc_full  = start && !busy && (i_tile_row_count != '0) &&
                       (i_tile_column_count != '0);
    assign acc_empty = start && !busy && ((i_tile_row_count == '0) ||
                       (i_tile_column_count == '0));

    `SBCC_NEVER(a_done_while_busy, i_clk, i_rst_n, o_done && busy,
        "result strobe while busy")
    `SBCC_ASSERT(a_full_goes_busy, i_clk, i_rst_n, acc_full |=> busy,
        "non-empty item did not start a scan")
    `SBCC_ASSERT(a_empty_zero, i_clk, i_rst_n,
        acc_empty |=> (o_done && (o_conflict_total == '0)),
        "empty tile did not give zero next cycle")
    `SBCC_ASSERT(a_end_strobes, i_clk, i_rst_n, $fell(busy) |-> o_done,
        "scan ended without a result")

endmodule

bind swizzled_bank_conflict_counter_core sbcc_checker u_sbcc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .i_tile_row_count    (i_tile_row_count),
    .i_tile_column_count (i_tile_column_count),
    .o_done              (o_done),
    .o_conflict_total    (o_conflict_total)
);
